/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the quantised hard swish block.
// Depends on nothing; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/qhs_pkg.sv */
// Package for the quantised hard swish block: register map, widths and rounding helpers.
// Depends on nothing; imported by quantized_hard_swish_top, the checker and the testbench.
package qhs_pkg;

   localparam int LATENCY = 9;

   localparam int ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_INPUT_ZERO   = 3'd0,
      REG_INPUT_SCALE  = 3'd1,
      REG_OUT_INV_SCALE = 3'd2,
      REG_OUTPUT_ZERO  = 3'd3,
      REG_SHIFT_AMOUNT = 3'd4,
      REG_GAIN         = 3'd5
   } csr_index_type;

   localparam logic [7:0]  RST_INPUT_ZERO    = 8'd0;
   localparam logic [23:0] RST_INPUT_SCALE   = 24'd65536;
   localparam logic [31:0] RST_OUT_INV_SCALE = 32'd65536;
   localparam logic [7:0]  RST_OUTPUT_ZERO   = 8'd0;
   localparam logic [23:0] RST_SHIFT_AMOUNT  = 24'd196608;
   localparam logic [15:0] RST_GAIN          = 16'd10923;

   localparam logic [7:0] BYTE_MAX = 8'd255;

   // |a| at or above 2^40 certainly saturates the byte result
   localparam logic signed [61:0] SAT_LIMIT = 62'sh100_0000_0000;

   // magnitude / 2^16, round half to even
   function automatic logic [63:0] rne_shr16(input logic [63:0] m);
      logic [63:0] q;
      logic [15:0] r;
      q = m >> 16;
      r = m[15:0];
      if ((r > 16'h8000) || ((r == 16'h8000) && q[0])) begin
         q = q + 64'd1;
      end
      return q;
   endfunction

   // magnitude / 2^32, round half to even
   function automatic logic [63:0] rne_shr32(input logic [63:0] m);
      logic [63:0] q;
      logic [31:0] r;
      q = m >> 32;
      r = m[31:0];
      if ((r > 32'h8000_0000) || ((r == 32'h8000_0000) && q[0])) begin
         q = q + 64'd1;
      end
      return q;
   endfunction

endpackage

/* hw/rtl/quantized_hard_swish_top.sv */
// Quantised hard swish: nine-stage pipeline from input byte to saturated result byte.
// Depends on qhs_pkg and assert_macros.svh.
//
// Use:
//   Input channel: drive req_sample with start high; the sample transfers at the
//   clock edge where start is high and busy is low. busy is never raised, so one
//   sample may transfer in every cycle.
//   Result channel: rsp_valid is high for exactly one cycle with rsp_activation;
//   the result transfers at the edge ending that cycle. The receiver cannot stall.
//   Order: results leave in sample order, after passing all nine registered stages.
//   Throughput: one sample per cycle, set by the fully pipelined datapath (nine
//   registered stages, products in stages 1, 3, 5 and 7, none holds a sample twice).
//   Configuration: APB-style port, registers at byte addresses 4*index; writes
//   take effect at the access edge and should be made while the pipeline is empty.
//   Reset (synchronous, active high) restores the register defaults and clears
//   all in-flight samples; nothing is emitted for them.
module quantized_hard_swish_top
   import qhs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [7:0]          req_sample,
   output logic                rsp_valid,
   output logic [7:0]          rsp_activation,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

`include "assert_macros.svh"

   // configuration registers
   logic [7:0]  in_zero_ff;
   logic [23:0] in_scale_ff;
   logic [31:0] out_inv_ff;
   logic [7:0]  out_zero_ff;
   logic [23:0] shift_ff;
   logic [15:0] gain_ff;

   logic          csr_wr;
   csr_index_type csr_idx;

   assign pready  = 1'b1;
   assign busy    = 1'b0;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_idx = csr_index_type'(paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_zero_ff  <= RST_INPUT_ZERO;
         in_scale_ff <= RST_INPUT_SCALE;
         out_inv_ff  <= RST_OUT_INV_SCALE;
         out_zero_ff <= RST_OUTPUT_ZERO;
         shift_ff    <= RST_SHIFT_AMOUNT;
         gain_ff     <= RST_GAIN;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_INPUT_ZERO:    in_zero_ff  <= pwdata[7:0];
            REG_INPUT_SCALE:   in_scale_ff <= pwdata[23:0];
            REG_OUT_INV_SCALE: out_inv_ff  <= pwdata;
            REG_OUTPUT_ZERO:   out_zero_ff <= pwdata[7:0];
            REG_SHIFT_AMOUNT:  shift_ff    <= pwdata[23:0];
            REG_GAIN:          gain_ff     <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_INPUT_ZERO:    prdata = {24'd0, in_zero_ff};
         REG_INPUT_SCALE:   prdata = {8'd0, in_scale_ff};
         REG_OUT_INV_SCALE: prdata = out_inv_ff;
         REG_OUTPUT_ZERO:   prdata = {24'd0, out_zero_ff};
         REG_SHIFT_AMOUNT:  prdata = {8'd0, shift_ff};
         REG_GAIN:          prdata = {16'd0, gain_ff};
         default:           prdata = 32'd0;
      endcase
   end

   // valid bits travel alongside the datapath
   logic [LATENCY-1:0] vld_ff;
   logic [LATENCY-1:0] vld_in;

   assign vld_in = {vld_ff[LATENCY-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: dequantise, x = (sample - zero) * scale
   logic signed [8:0]  diff1;
   logic signed [33:0] xfull1;
   logic signed [32:0] x1_in, x1_ff;

   assign diff1  = $signed({1'b0, req_sample}) - $signed({1'b0, in_zero_ff});
   assign xfull1 = diff1 * $signed({1'b0, in_scale_ff});
   assign x1_in  = xfull1[32:0];

   // stage 2: t = clamp(x + shift, 0, 2*shift)
   logic signed [33:0] xs2;
   logic [24:0]        lim2;
   logic [24:0]        t2_in, t2_ff;
   logic signed [32:0] x2_ff;

   assign xs2  = $signed({x1_ff[32], x1_ff}) + $signed({10'd0, shift_ff});
   assign lim2 = {shift_ff, 1'b0};

   always_comb begin
      if (xs2[33]) begin
         t2_in = '0;
      end else if (xs2[32:0] > {8'd0, lim2}) begin
         t2_in = lim2;
      end else begin
         t2_in = xs2[24:0];
      end
   end

   // stage 3: t * gain
   logic [40:0]        p3_in, p3_ff;
   logic signed [32:0] x3_ff;

   assign p3_in = t2_ff * gain_ff;

   // stage 4: u = round(t * gain / 2^16)
   logic [63:0]        u4_full;
   logic [25:0]        u4_in, u4_ff;
   logic signed [32:0] x4_ff;

   assign u4_full = rne_shr16({23'd0, p3_ff});
   assign u4_in   = u4_full[25:0];

   // stage 5: x * u
   logic signed [59:0] p5_in, p5_ff;

   assign p5_in = x4_ff * $signed({1'b0, u4_ff});

   // stage 6: h = round(x * u / 2^16), symmetric about zero
   logic               neg6;
   logic [59:0]        mag6;
   logic [63:0]        q6_full;
   logic [44:0]        q6;
   logic signed [44:0] h6_in, h6_ff;

   assign neg6    = p5_ff[59];
   assign mag6    = neg6 ? 60'(-p5_ff) : 60'(p5_ff);
   assign q6_full = rne_shr16({4'd0, mag6});
   assign q6      = q6_full[44:0];
   assign h6_in   = neg6 ? -$signed(q6) : $signed(q6);

   // stage 7: split product by the output reciprocal scale
   logic signed [61:0] a7_in, a7_ff;
   logic signed [61:0] b7_in, b7_ff;

   assign a7_in = h6_ff * $signed({1'b0, out_inv_ff[31:16]});
   assign b7_in = h6_ff * $signed({1'b0, out_inv_ff[15:0]});

   // stage 8: saturation flags and recombined product
   logic               sat_hi8_in, sat_hi8_ff;
   logic               sat_lo8_in, sat_lo8_ff;
   logic signed [62:0] sum8_in, sum8_ff;

   assign sat_hi8_in = a7_ff >= SAT_LIMIT;
   assign sat_lo8_in = a7_ff <= -SAT_LIMIT;
   assign sum8_in    = $signed({a7_ff[46:0], 16'd0}) + $signed({b7_ff[61], b7_ff});

   // stage 9: round by 2^32, add zero point, saturate to a byte
   logic               neg9;
   logic [62:0]        mag9;
   logic [63:0]        q9_full;
   logic [31:0]        q9;
   logic signed [33:0] sq9;
   logic signed [33:0] r9;
   logic [7:0]         act9_in, act9_ff;

   assign neg9    = sum8_ff[62];
   assign mag9    = neg9 ? 63'(-sum8_ff) : 63'(sum8_ff);
   assign q9_full = rne_shr32({1'b0, mag9});
   assign q9      = q9_full[31:0];
   assign sq9     = neg9 ? -$signed({2'b0, q9}) : $signed({2'b0, q9});
   assign r9      = sq9 + $signed({26'd0, out_zero_ff});

   always_comb begin
      if (sat_hi8_ff) begin
         act9_in = BYTE_MAX;
      end else if (sat_lo8_ff || r9[33]) begin
         act9_in = '0;
      end else if (r9 > $signed({26'd0, BYTE_MAX})) begin
         act9_in = BYTE_MAX;
      end else begin
         act9_in = r9[7:0];
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      x1_ff      <= x1_in;
      t2_ff      <= t2_in;
      x2_ff      <= x1_ff;
      p3_ff      <= p3_in;
      x3_ff      <= x2_ff;
      u4_ff      <= u4_in;
      x4_ff      <= x3_ff;
      p5_ff      <= p5_in;
      h6_ff      <= h6_in;
      a7_ff      <= a7_in;
      b7_ff      <= b7_in;
      sat_hi8_ff <= sat_hi8_in;
      sat_lo8_ff <= sat_lo8_in;
      sum8_ff    <= sum8_in;
      act9_ff    <= act9_in;
   end

   assign rsp_valid      = vld_ff[LATENCY-1];
   assign rsp_activation = act9_ff;

   `ASSERT_IMPL(a_fixed_latency, clock, reset, start && !busy, ##LATENCY rsp_valid)
   `ASSERT_NEXT(a_sat_high, clock, reset, vld_ff[LATENCY-2] && sat_hi8_ff, rsp_activation == BYTE_MAX)
   `ASSERT_NEXT(a_sat_low, clock, reset, vld_ff[LATENCY-2] && sat_lo8_ff, rsp_activation == 8'd0)

endmodule

/* verif/quantized_hard_swish_checker.sv */
`timescale 1ns / 100ps
// Checker for the quantised hard swish block: tracks register writes, predicts each result
// byte in fixed point and compares it with the result transfers. Depends on qhs_pkg.
module quantized_hard_swish_checker
   import qhs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [7:0]        req_sample,
   input  logic              rsp_valid,
   input  logic [7:0]        rsp_activation,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output int                failures,
   output int                pending,
   output int                compared
);

   localparam longint SAT_BOUND = longint'(1) << 40;
   localparam longint ACT_MAX   = 255;

   logic [7:0]  zero_in;
   logic [23:0] scale_in;
   logic [31:0] inv_scale_out;
   logic [7:0]  zero_out;
   logic [23:0] swish_shift;
   logic [15:0] swish_gain;

   logic [7:0] expected_activations[$];
   logic [7:0] oldest;

   initial begin
      failures = 0;
      pending  = 0;
      compared = 0;
   end

   // v / 2^s, ties to even, symmetric about zero
   function automatic longint round_even_shr(input longint v, input int unsigned s);
      logic [63:0] mag;
      logic [63:0] quo;
      logic [63:0] rem;
      logic [63:0] half;
      mag  = (v < 0) ? 64'(-v) : 64'(v);
      quo  = mag >> s;
      rem  = mag & ((64'd1 << s) - 64'd1);
      half = 64'd1 << (s - 1);
      if ((rem > half) || ((rem == half) && quo[0])) begin
         quo = quo + 64'd1;
      end
      return (v < 0) ? -longint'(quo) : longint'(quo);
   endfunction

   function automatic logic [7:0] hard_swish_byte(input logic [7:0] sample);
      longint x;
      longint sh;
      longint t;
      longint u;
      longint h;
      longint a;
      longint b;
      longint r;
      x  = (longint'({56'd0, sample}) - longint'({56'd0, zero_in}))
           * longint'({40'd0, scale_in});
      sh = longint'({40'd0, swish_shift});
      t  = x + sh;
      if (t < 0) begin
         t = 0;
      end
      if (t > 2 * sh) begin
         t = 2 * sh;
      end
      u = round_even_shr(t * longint'({48'd0, swish_gain}), 16);
      h = round_even_shr(x * u, 16);
      a = h * longint'({48'd0, inv_scale_out[31:16]});
      b = h * longint'({48'd0, inv_scale_out[15:0]});
      if (a >= SAT_BOUND) begin
         r = ACT_MAX;
      end else if (a <= -SAT_BOUND) begin
         r = 0;
      end else begin
         r = round_even_shr(a * 65536 + b, 32) + longint'({56'd0, zero_out});
         if (r < 0) begin
            r = 0;
         end
         if (r > ACT_MAX) begin
            r = ACT_MAX;
         end
      end
      return r[7:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         zero_in       = 8'd0;
         scale_in      = 24'd65536;
         inv_scale_out = 32'd65536;
         zero_out      = 8'd0;
         swish_shift   = 24'd196608;
         swish_gain    = 16'd10923;
         expected_activations.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_activations.size() == 0) begin
               $error("activation transfer with nothing outstanding: actual %0d",
                      rsp_activation);
               failures++;
            end else begin
               oldest = expected_activations.pop_front();
               compared++;
               if (rsp_activation !== oldest) begin
                  $error("activation mismatch: expected %0d, actual %0d",
                         oldest, rsp_activation);
                  failures++;
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[ADDR_W-1:2]))
               REG_INPUT_ZERO:    zero_in       = pwdata[7:0];
               REG_INPUT_SCALE:   scale_in      = pwdata[23:0];
               REG_OUT_INV_SCALE: inv_scale_out = pwdata;
               REG_OUTPUT_ZERO:   zero_out      = pwdata[7:0];
               REG_SHIFT_AMOUNT:  swish_shift   = pwdata[23:0];
               REG_GAIN:          swish_gain    = pwdata[15:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            expected_activations.push_back(hard_swish_byte(req_sample));
         end
      end
      pending = expected_activations.size();
   end

endmodule

/* verif/quantized_hard_swish_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top for quantized_hard_swish_top: clock, reset, register settings and sample
// stimulus with random gaps; checking is done by quantized_hard_swish_checker. Uses qhs_pkg.
module quantized_hard_swish_top_tb
   import qhs_pkg::*;
();

   // register slots past the map; writes there must be ignored
   localparam int unsigned UNMAPPED_LOW  = 6;
   localparam int unsigned UNMAPPED_HIGH = 7;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_SAMPLES = 104;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              start      = 1'b0;
   logic [7:0]        req_sample = 8'd0;
   logic              psel       = 1'b0;
   logic              penable    = 1'b0;
   logic              pwrite     = 1'b0;
   logic [ADDR_W-1:0] paddr      = '0;
   logic [31:0]       pwdata     = 32'd0;
   logic              busy;
   logic              rsp_valid;
   logic [7:0]        rsp_activation;
   logic [31:0]       prdata;
   logic              pready;

   int failures;
   int pending;
   int compared;
   int sent    = 0;
   int configs = 0;

   always #1 clock = ~clock;

   quantized_hard_swish_top uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_activation (rsp_activation),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   quantized_hard_swish_checker swish_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_activation (rsp_activation),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .failures       (failures),
      .pending        (pending),
      .compared       (compared)
   );

   // holds start high until the sample transfers
   task automatic send_sample(input logic [7:0] value);
      logic was_busy;
      start      <= 1'b1;
      req_sample <= value;
      do begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
      end while (was_busy);
      sent++;
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained;
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   // setup then access; select is left high for a following write
   task automatic write_csr(input int unsigned index, input logic [31:0] value);
      logic ready;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(index * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         ready = pready;
         @(posedge clock);
      end while (!ready);
   endtask

   task automatic load_config(input logic [7:0] iz, input logic [23:0] isc,
                              input logic [31:0] ois, input logic [7:0] oz,
                              input logic [23:0] sh, input logic [15:0] g);
      wait_drained();
      write_csr(REG_INPUT_ZERO, {24'd0, iz});
      write_csr(REG_INPUT_SCALE, {8'd0, isc});
      write_csr(REG_OUT_INV_SCALE, ois);
      write_csr(REG_OUTPUT_ZERO, {24'd0, oz});
      write_csr(REG_SHIFT_AMOUNT, {8'd0, sh});
      write_csr(REG_GAIN, {16'd0, g});
      write_csr($urandom_range(0, 1) ? UNMAPPED_LOW : UNMAPPED_HIGH, $urandom());
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      configs++;
   endtask

   task automatic run_random_phase(input int count, input bit allow_gaps);
      bit steady;
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < count; i++) begin
         send_sample(8'($urandom_range(0, 255)));
         if (allow_gaps && !steady && ($urandom_range(0, 3) == 0)) begin
            pause_sender($urandom_range(1, 18));
         end
         if (allow_gaps && ($urandom_range(0, 39) == 0)) begin
            steady = !steady;
         end
      end
   endtask

   initial begin
      logic [7:0] burst[$];
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // register defaults: input and output scale 1.0, shift 3.0, gain one sixth
      burst = '{8'd0, 8'd1, 8'd3, 8'd127, 8'd128, 8'd254, 8'd255};
      foreach (burst[i]) send_sample(burst[i]);

      // every register at its top value
      load_config(8'hFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 24'hFF_FFFF, 16'hFFFF);
      burst = '{8'd0, 8'd254, 8'd255};
      foreach (burst[i]) send_sample(burst[i]);

      // positive products far past the byte range
      load_config(8'd0, 24'hFF_FFFF, 32'hFFFF_FFFF, 8'd0, 24'hFF_FFFF, 16'hFFFF);
      burst = '{8'd0, 8'd1, 8'd255};
      foreach (burst[i]) send_sample(burst[i]);

      // negative products far past the byte range, inside the swish dip
      load_config(8'd128, 24'd65536, 32'hFFFF_FFFF, 8'd200, 24'hFF_FFFF, 16'hFFFF);
      burst = '{8'd0, 8'd64, 8'd128, 8'd255};
      foreach (burst[i]) send_sample(burst[i]);

      // zero scales give the output zero point
      load_config(8'd0, 24'd0, 32'd0, 8'd77, 24'd196608, 16'd10923);
      burst = '{8'd0, 8'd255};
      foreach (burst[i]) send_sample(burst[i]);

      // zero shift: activation is the output zero point everywhere
      load_config(8'd10, 24'd65536, 32'd65536, 8'd50, 24'd0, 16'd10923);
      burst = '{8'd0, 8'd200};
      foreach (burst[i]) send_sample(burst[i]);

      load_config(8'd0, 24'd0, 32'd0, 8'd0, 24'd0, 16'd0);
      send_sample(8'd255);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if ($urandom_range(0, 2) == 0) begin
            load_config(8'($urandom()), 24'($urandom()), $urandom(), 8'($urandom()),
                        24'($urandom()), 16'($urandom()));
         end else begin
            load_config(8'($urandom_range(0, 255)), 24'($urandom_range(1000, 40000)),
                        $urandom_range(262144, 4194304), 8'($urandom_range(0, 255)),
                        ($urandom_range(0, 1) ? 24'd196608 : 24'($urandom_range(0, 1 << 20))),
                        ($urandom_range(0, 1) ? 16'd10923 : 16'($urandom())));
         end
         run_random_phase(PHASE_SAMPLES, p != RANDOM_PHASES - 1);
      end

      wait_drained();
      repeat (LATENCY + 2) @(posedge clock);
      @(negedge clock);
      $display("Sent %0d samples across %0d register settings, including saturation,", sent,
               configs);
      $display("zero scales, zero shift and unmapped writes; %0d results compared.", compared);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #500000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/qhs_pkg.sv
hw/rtl/quantized_hard_swish_top.sv
verif/quantized_hard_swish_checker.sv
verif/quantized_hard_swish_top_tb.sv
